// ===== src/m3i_pkg.sv =====
// m3i_pkg: shared constants for the 3x3 matrix inverse pipeline.
// Holds fixed-point formats and the cofactor product index tables.
// No dependencies.
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int InFrac  = 12;
  localparam int OutFrac = 16;
  localparam int QShift  = InFrac + OutFrac;
  localparam int OutW    = 32;
  localparam int NumEnt  = 9;
  localparam int NumProd = 18;

  typedef logic [3:0] idx_t;

  // cofactor k = a[CP_A[2k]]*a[CP_B[2k]] - a[CP_A[2k+1]]*a[CP_B[2k+1]]
  localparam idx_t CP_A [NumProd] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam idx_t CP_B [NumProd] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  localparam logic [OutW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0] NegMax = 32'h8000_0000;
endpackage

// ===== src/matrix3_inverse.sv =====
// matrix3_inverse: 3x3 fixed-point matrix inverse by adjugate over determinant.
// Stages: 4 cofactor/determinant stages, one divider stage per quotient bit, 1 merge stage.
// Throughput: one matrix per cycle while the pipeline advances; the nine divider lanes are fully pipelined.
// The whole pipeline advances when the output register is empty or taken.
// Reset (rst_ni, async low) clears only the valid bits; no flush is needed.
`timescale 1ns / 1ps
module matrix3_inverse #(
  parameter int ENTRY_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ENTRY_WIDTH-1:0] a00_i,
  input  logic signed [ENTRY_WIDTH-1:0] a01_i,
  input  logic signed [ENTRY_WIDTH-1:0] a02_i,
  input  logic signed [ENTRY_WIDTH-1:0] a10_i,
  input  logic signed [ENTRY_WIDTH-1:0] a11_i,
  input  logic signed [ENTRY_WIDTH-1:0] a12_i,
  input  logic signed [ENTRY_WIDTH-1:0] a20_i,
  input  logic signed [ENTRY_WIDTH-1:0] a21_i,
  input  logic signed [ENTRY_WIDTH-1:0] a22_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            inv00_o,
  output logic signed [31:0]            inv01_o,
  output logic signed [31:0]            inv02_o,
  output logic signed [31:0]            inv10_o,
  output logic signed [31:0]            inv11_o,
  output logic signed [31:0]            inv12_o,
  output logic signed [31:0]            inv20_o,
  output logic signed [31:0]            inv21_o,
  output logic signed [31:0]            inv22_o,
  output logic                          singular_o,
  output logic                          saturated_o
);
  localparam int W = ENTRY_WIDTH;
  localparam int NB = 2 * W + m3i_pkg::QShift;
  localparam int NE = m3i_pkg::NumEnt;
  localparam int OW = m3i_pkg::OutW;
  localparam int FD = 4;

  logic en;
  logic signed [W-1:0] a [NE];
  logic [2*W-1:0] cmag [NE];
  logic           cneg [NE];
  logic [3*W-1:0] dmag;
  logic           sing;
  logic [NB-1:0]  quo [NE];
  logic           qneg [NE];

  logic [FD-1:0]  fv_q;
  logic [NB-1:0]  dv_q;
  logic [NB-1:0]  ds_q;
  logic           ovld_q;
  logic [OW-1:0]  res_q [NE];
  logic           sing_q, sat_q;
  logic [OW-1:0]  res_d [NE];
  logic           sat_d;

  assign en = !ovld_q || out_ready_i;
  assign in_ready_o = en;

  assign a[0] = a00_i; assign a[1] = a01_i; assign a[2] = a02_i;
  assign a[3] = a10_i; assign a[4] = a11_i; assign a[5] = a12_i;
  assign a[6] = a20_i; assign a[7] = a21_i; assign a[8] = a22_i;

  m3i_cofactor #(.W(W)) u_cof (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a),
    .cmag_o (cmag),
    .cneg_o (cneg),
    .dmag_o (dmag),
    .sing_o (sing)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    m3i_div_lane #(.W(W)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .cmag_i (cmag[k]),
      .neg_i  (cneg[k]),
      .dmag_i (dmag),
      .quo_o  (quo[k]),
      .neg_o  (qneg[k])
    );
  end

  always_comb begin
    logic [OW-1:0] lim;
    logic          ovf;
    sat_d = 1'b0;
    for (int k = 0; k < NE; k++) begin
      lim = qneg[k] ? m3i_pkg::NegMax : m3i_pkg::PosMax;
      ovf = (quo[k][NB-1:OW] != '0) || (quo[k][OW-1:0] > lim);
      if (ds_q[NB-1]) begin
        res_d[k] = '0;
      end else if (ovf) begin
        res_d[k] = lim;
        sat_d = 1'b1;
      end else begin
        res_d[k] = qneg[k] ? -quo[k][OW-1:0] : quo[k][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q   <= '0;
      dv_q   <= '0;
      ovld_q <= 1'b0;
    end else if (en) begin
      fv_q   <= {fv_q[FD-2:0], in_valid_i};
      dv_q   <= {dv_q[NB-2:0], fv_q[FD-1]};
      ovld_q <= dv_q[NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q   <= {ds_q[NB-2:0], sing};
      res_q  <= res_d;
      sing_q <= ds_q[NB-1];
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign inv00_o = res_q[0]; assign inv01_o = res_q[1]; assign inv02_o = res_q[2];
  assign inv10_o = res_q[3]; assign inv11_o = res_q[4]; assign inv12_o = res_q[5];
  assign inv20_o = res_q[6]; assign inv21_o = res_q[7]; assign inv22_o = res_q[8];
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;
endmodule

// ===== src/m3i_cofactor.sv =====
// m3i_cofactor: four-stage pipeline forming cofactors, determinant and magnitudes.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_cofactor #(
  parameter int W = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [W-1:0]    a_i    [m3i_pkg::NumEnt],
  output logic        [2*W-1:0]  cmag_o [m3i_pkg::NumEnt],
  output logic                   cneg_o [m3i_pkg::NumEnt],
  output logic        [3*W-1:0]  dmag_o,
  output logic                   sing_o
);
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int DPW = 3 * W + 1;
  localparam int DW = 3 * W + 3;

  logic signed [PW-1:0]  prod_q [m3i_pkg::NumProd];
  logic signed [W-1:0]   r0_q [3];
  logic signed [W-1:0]   r1_q [3];
  logic signed [W-1:0]   r2_q [3];
  logic signed [CW-1:0]  cof_q [m3i_pkg::NumEnt];
  logic signed [CW-1:0]  cof2_q [m3i_pkg::NumEnt];
  logic signed [DPW-1:0] dp_q [3];
  logic signed [DW-1:0]  det;
  logic signed [DW-1:0]  dneg_v;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < m3i_pkg::NumProd; j++) begin
        prod_q[j] <= PW'(a_i[m3i_pkg::CP_A[j]]) * PW'(a_i[m3i_pkg::CP_B[j]]);
      end
      for (int j = 0; j < 3; j++) begin
        r0_q[j] <= a_i[j];
        r1_q[j] <= r0_q[j];
        r2_q[j] <= r1_q[j];
      end
      for (int k = 0; k < m3i_pkg::NumEnt; k++) begin
        cof_q[k]  <= CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
        cof2_q[k] <= cof_q[k];
      end
      dp_q[0] <= DPW'(r1_q[0]) * DPW'(cof_q[0]);
      dp_q[1] <= DPW'(r1_q[1]) * DPW'(cof_q[3]);
      dp_q[2] <= DPW'(r1_q[2]) * DPW'(cof_q[6]);
    end
  end

  assign det    = DW'(dp_q[0]) + DW'(dp_q[1]) + DW'(dp_q[2]);
  assign dneg_v = -det;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < m3i_pkg::NumEnt; k++) begin
        cmag_o[k] <= cof2_q[k][CW-1] ? PW'(-cof2_q[k]) : PW'(cof2_q[k]);
        cneg_o[k] <= cof2_q[k][CW-1] ^ det[DW-1];
      end
      dmag_o <= det[DW-1] ? dneg_v[3*W-1:0] : det[3*W-1:0];
      sing_o <= (det == '0);
    end
  end
endmodule

// ===== src/m3i_div_lane.sv =====
// m3i_div_lane: pipelined restoring divider, one quotient bit per stage.
// Divides (cmag << QShift) by dmag. Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_div_lane #(
  parameter int W = 16
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [2*W-1:0]                         cmag_i,
  input  logic                                   neg_i,
  input  logic [3*W-1:0]                         dmag_i,
  output logic [2*W+m3i_pkg::QShift-1:0]         quo_o,
  output logic                                   neg_o
);
  localparam int NB = 2 * W + m3i_pkg::QShift;
  localparam int DW = 3 * W;

  logic [DW-1:0] rem_q [NB];
  logic [NB-1:0] quo_q [NB];
  logic [NB-1:0] num_q [NB];
  logic [DW-1:0] den_q [NB];
  logic          neg_q [NB];

  logic [DW-1:0] rem_d [NB];
  logic [NB-1:0] quo_d [NB];

  always_comb begin
    logic [DW:0]   rr;
    logic [DW-1:0] rin;
    logic [NB-1:0] qin;
    logic [NB-1:0] nin;
    logic [DW-1:0] din;
    for (int s = 0; s < NB; s++) begin
      rin = (s == 0) ? '0 : rem_q[(s == 0) ? 0 : s-1];
      qin = (s == 0) ? '0 : quo_q[(s == 0) ? 0 : s-1];
      nin = (s == 0) ? {cmag_i, m3i_pkg::QShift'(0)} : num_q[(s == 0) ? 0 : s-1];
      din = (s == 0) ? dmag_i : den_q[(s == 0) ? 0 : s-1];
      rr = {rin, nin[NB-1-s]};
      if (rr >= {1'b0, din}) begin
        rem_d[s] = DW'(rr - {1'b0, din});
        quo_d[s] = qin | (NB'(1) << (NB-1-s));
      end else begin
        rem_d[s] = rr[DW-1:0];
        quo_d[s] = qin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NB; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end
      num_q[0] <= {cmag_i, m3i_pkg::QShift'(0)};
      den_q[0] <= dmag_i;
      neg_q[0] <= neg_i;
      for (int s = 1; s < NB; s++) begin
        num_q[s] <= num_q[s-1];
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[NB-1];
  assign neg_o = neg_q[NB-1];
endmodule

// ===== tb/testbench.sv =====
// testbench: random and directed check of matrix3_inverse against a built-in predictor.
// Depends on src/m3i_pkg.sv and src/matrix3_inverse.sv, which needs src/m3i_cofactor.sv and src/m3i_div_lane.sv.
`timescale 1ns / 1ps
module testbench;
  localparam int EW = 16;
  localparam int Latency = 2 * EW + 33;

  typedef logic signed [EW-1:0] entry_t;
  typedef struct packed {
    entry_t [8:0] a;
  } matrix_t;
  typedef struct packed {
    logic [8:0][m3i_pkg::OutW-1:0] inv;
    logic singular;
    logic saturated;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  entry_t a_i [9];
  logic signed [31:0] inv_o [9];
  logic singular_o, saturated_o;

  matrix_t pending_q[$];
  inverse_t inverse_q[$];
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit stim_done = 1'b0;
  bit in_fire = 1'b0;

  always #5 clk_i = ~clk_i;

  matrix3_inverse #(.ENTRY_WIDTH(EW)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a00_i(a_i[0]), .a01_i(a_i[1]), .a02_i(a_i[2]),
    .a10_i(a_i[3]), .a11_i(a_i[4]), .a12_i(a_i[5]),
    .a20_i(a_i[6]), .a21_i(a_i[7]), .a22_i(a_i[8]),
    .out_valid_o, .out_ready_i,
    .inv00_o(inv_o[0]), .inv01_o(inv_o[1]), .inv02_o(inv_o[2]),
    .inv10_o(inv_o[3]), .inv11_o(inv_o[4]), .inv12_o(inv_o[5]),
    .inv20_o(inv_o[6]), .inv21_o(inv_o[7]), .inv22_o(inv_o[8]),
    .singular_o, .saturated_o
  );

  function automatic inverse_t invert(matrix_t m);
    inverse_t r;
    logic signed [63:0] e [9];
    logic signed [63:0] c [9];
    logic signed [127:0] det, dmag, num, q;
    logic neg;
    r = '0;
    for (int i = 0; i < 9; i++) e[i] = m.a[i];
    c[0] = e[4] * e[8] - e[5] * e[7];
    c[1] = e[2] * e[7] - e[1] * e[8];
    c[2] = e[1] * e[5] - e[2] * e[4];
    c[3] = e[5] * e[6] - e[3] * e[8];
    c[4] = e[0] * e[8] - e[2] * e[6];
    c[5] = e[2] * e[3] - e[0] * e[5];
    c[6] = e[3] * e[7] - e[4] * e[6];
    c[7] = e[1] * e[6] - e[0] * e[7];
    c[8] = e[0] * e[4] - e[1] * e[3];
    det = 128'(e[0]) * 128'(c[0]) + 128'(e[1]) * 128'(c[3]) + 128'(e[2]) * 128'(c[6]);
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < 9; i++) begin
      neg = (c[i] < 0) != (det < 0);
      num = (c[i] < 0 ? -128'(c[i]) : 128'(c[i])) <<< m3i_pkg::QShift;
      q = num / dmag;
      if (q > (neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF)) begin
        r.saturated = 1'b1;
        r.inv[i] = neg ? m3i_pkg::NegMax : m3i_pkg::PosMax;
      end else begin
        r.inv[i] = neg ? m3i_pkg::OutW'(-q) : m3i_pkg::OutW'(q);
      end
    end
    return r;
  endfunction

  function automatic entry_t rand_entry();
    case ($urandom_range(0, 5))
      0: return entry_t'(int'($urandom_range(0, 8)) - 4);
      1: return entry_t'(16'h7FFF - $urandom_range(0, 3));
      2: return entry_t'(16'h8000 + $urandom_range(0, 3));
      3: return entry_t'(4096 * ($urandom_range(0, 6) - 3));
      default: return entry_t'($urandom);
    endcase
  endfunction

  function automatic matrix_t diag(entry_t v);
    matrix_t m;
    m = '0;
    m.a[0] = v;
    m.a[4] = v;
    m.a[8] = v;
    return m;
  endfunction

  initial begin
    matrix_t m;
    pending_q.push_back(diag(16'sd4096));
    pending_q.push_back(diag(16'sd1));
    pending_q.push_back(diag(16'sh7FFF));
    pending_q.push_back(diag(16'sh8000));
    pending_q.push_back(diag(-16'sd4096));
    pending_q.push_back('0);
    m = '1;
    pending_q.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = 16'sh7FFF;
    pending_q.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
    pending_q.push_back(m);
    m = diag(16'sd4096);
    m.a[1] = 16'sh8000;
    m.a[5] = 16'sh7FFF;
    pending_q.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = entry_t'(i + 1);
    pending_q.push_back(m);
    m = '0;
    m.a[2] = 16'sh8000;
    m.a[4] = 16'sh8000;
    m.a[6] = 16'sh8000;
    pending_q.push_back(m);
    m = diag(16'sd2);
    m.a[0] = 16'sd1;
    pending_q.push_back(m);
    for (int n = 0; n < 500; n++) begin
      for (int i = 0; i < 9; i++) m.a[i] = rand_entry();
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 3; i++) m.a[6 + i] = m.a[i];
      end
      pending_q.push_back(m);
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          for (int i = 0; i < 9; i++) a_i[i] <= pending_q[0].a[i];
          in_valid_i <= 1'b1;
          in_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end else begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                   ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      end
    end
  end

  initial foreach (a_i[i]) a_i[i] = '0;

  always @(posedge clk_i) begin
    inverse_t exp_r;
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      inverse_q.push_back(invert(pending_q.pop_front()));
    end
    if (out_valid_o && out_ready_i) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected transaction", $time);
        errors++;
      end else begin
        exp_r = inverse_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (inv_o[i] !== exp_r.inv[i]) begin
            $display("%0t: inv%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                     exp_r.inv[i], inv_o[i]);
            errors++;
          end
        end
        if (singular_o !== exp_r.singular) begin
          $display("%0t: singular expected %b actual %b", $time, exp_r.singular, singular_o);
          errors++;
        end
        if (saturated_o !== exp_r.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_r.saturated,
                   saturated_o);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && inverse_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
    end
  end
endmodule
